// File: rtl/core/tgps_pkg.sv
// Package for the Gouraud triangle pixel shader.
// Holds shared widths, command codes and the front-to-back transaction type.
// No dependencies.
package tgps_pkg;

    localparam int CoordBits = 11;
    localparam int EdgeBits  = 2 * CoordBits + 3;
    localparam int NumBits   = EdgeBits + 8 + 2;
    localparam int QDepth    = 4;
    localparam int QIdxBits  = 2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SHADE = 1'b1;

    typedef logic signed [CoordBits-1:0] t_coord;
    typedef logic signed [EdgeBits-1:0]  t_edge;

    // Pixel transaction passed from front to back
    typedef struct packed {
        logic        covered;
        logic        gouraud;
        t_edge       e0;
        t_edge       e1;
        t_edge       e2;
        t_edge       area;
        logic [23:0] c0;
        logic [23:0] c1;
        logic [23:0] c2;
    } t_pix;

endpackage

// File: rtl/core/tgps_if.sv
// Channel interfaces for the shader: valid/ready plus payload.
// Depends on tgps_pkg for the coordinate width.
interface tgps_in_if;
    logic                               valid;
    logic                               ready;
    logic                               command;
    logic [1:0]                         vertex_index;
    logic signed [tgps_pkg::CoordBits-1:0] pos_x;
    logic signed [tgps_pkg::CoordBits-1:0] pos_y;
    logic [23:0]                        vertex_rgb;
    modport source (output valid, command, vertex_index, pos_x, pos_y, vertex_rgb,
                    input ready);
    modport sink (input valid, command, vertex_index, pos_x, pos_y, vertex_rgb,
                  output ready);
endinterface

interface tgps_out_if;
    logic       valid;
    logic       ready;
    logic       covered;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, covered, red, green, blue, input ready);
    modport sink (input valid, covered, red, green, blue, output ready);
endinterface

// File: rtl/core/triangle_gouraud_pixel_shader.sv
// Gouraud triangle pixel shader: per-pixel coverage and colour interpolation.
// Channel i_in takes vertex loads and pixel transactions; o_out gives one
// transaction per pixel. i_shade_mode_we/i_shade_mode_wd write the shade mode
// (reset 1, Gouraud). Loads give no result and take effect for the next pixel.
// Throughput: one transaction per cycle; front, queue and back stall apart.
// Stages: the front registers edge products, then edge sums; pixels then
// pass through the queue; the back registers colour products, sums, sign fold
// and an eight-stage divider, one per quotient bit.
// Reset (synchronous, active low) clears vertices to zero, empties the queue
// and pipelines and sets Gouraud mode. When the receiver stalls the back end
// holds, the queue fills, then the front end drops ready.
// Depends on tgps_pkg, tgps_if, tgps_front, tgps_queue, tgps_back.
module triangle_gouraud_pixel_shader (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shade_mode_we,
    input  logic          i_shade_mode_wd,
    tgps_in_if.sink       i_in,
    tgps_out_if.source    o_out
);
    logic           r_mode;
    logic           f_valid, f_ready, q_valid, q_ready;
    tgps_pkg::t_pix f_pix, q_pix;

    // Hold shade mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
        end else if (i_shade_mode_we) begin
            r_mode <= i_shade_mode_wd;
        end
    end

    tgps_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_shade_mode   (r_mode),
        .i_valid        (i_in.valid),
        .o_ready        (i_in.ready),
        .i_command      (i_in.command),
        .i_vertex_index (i_in.vertex_index),
        .i_pos_x        (i_in.pos_x),
        .i_pos_y        (i_in.pos_y),
        .i_vertex_rgb   (i_in.vertex_rgb),
        .o_valid        (f_valid),
        .i_ready        (f_ready),
        .o_pix          (f_pix)
    );

    tgps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_pix   (f_pix),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_pix   (q_pix)
    );

    tgps_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .o_ready   (q_ready),
        .i_pix     (q_pix),
        .o_valid   (o_out.valid),
        .i_ready   (o_out.ready),
        .o_covered (o_out.covered),
        .o_red     (o_out.red),
        .o_green   (o_out.green),
        .o_blue    (o_out.blue)
    );
endmodule

// File: rtl/core/tgps_front.sv
// Front end: holds vertices, computes edge functions and coverage per pixel.
// Depends on tgps_pkg. Two register stages, stalls on downstream ready.
module tgps_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_shade_mode,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic [1:0]         i_vertex_index,
    input  tgps_pkg::t_coord   i_pos_x,
    input  tgps_pkg::t_coord   i_pos_y,
    input  logic [23:0]        i_vertex_rgb,
    output logic               o_valid,
    input  logic               i_ready,
    output tgps_pkg::t_pix     o_pix
);
    localparam int EB = tgps_pkg::EdgeBits;
    localparam int PB = tgps_pkg::CoordBits + 2;

    tgps_pkg::t_coord r_vx [3];
    tgps_pkg::t_coord r_vy [3];
    logic [23:0]      r_vc [3];

    // Stage 1 registers: products
    logic             r_s1_valid;
    logic             r_s1_mode;
    logic [23:0]      r_s1_c [3];
    logic signed [EB-1:0] r_p [3][3];
    logic signed [EB-1:0] r_area;

    // Stage 2 registers
    logic             r_s2_valid;
    tgps_pkg::t_pix   r_pix;

    logic adv2, adv1, acc;
    logic signed [EB-1:0] n_area;
    logic signed [PB-1:0] dy [3];
    logic signed [PB-1:0] dx [3];
    logic signed [EB-1:0] n_p [3][3];
    logic signed [EB-1:0] e [3];
    logic signed [EB-1:0] px, py;
    logic                 cov;

    assign adv2    = !r_s2_valid || i_ready;
    assign adv1    = !r_s1_valid || adv2;
    assign o_ready = adv1;
    assign acc     = i_valid && adv1;
    assign px      = EB'(i_pos_x);
    assign py      = EB'(i_pos_y);

    // Edge coefficients for edges (1,2), (2,0), (0,1)
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dy[k] = PB'(r_vy[(k + 1) % 3]) - PB'(r_vy[(k + 2) % 3]);
            dx[k] = PB'(r_vx[(k + 2) % 3]) - PB'(r_vx[(k + 1) % 3]);
            n_p[k][0] = EB'(dy[k]) * px;
            n_p[k][1] = EB'(dx[k]) * py;
            n_p[k][2] = EB'(r_vx[(k + 1) % 3]) * EB'(r_vy[(k + 2) % 3])
                      - EB'(r_vx[(k + 2) % 3]) * EB'(r_vy[(k + 1) % 3]);
        end
        n_area = EB'(dy[2]) * EB'(r_vx[2]) + EB'(dx[2]) * EB'(r_vy[2]) + n_p[2][2];
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e[k] = r_p[k][0] + r_p[k][1] + r_p[k][2];
        end
        cov = (r_area != 0);
        for (int k = 0; k < 3; k++) begin
            if (e[k] != 0 && (e[k][EB-1] != r_area[EB-1])) begin
                cov = 1'b0;
            end
        end
    end

    // Vertex store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_vx[k] <= '0;
                r_vy[k] <= '0;
                r_vc[k] <= '0;
            end
        end else if (acc && i_command == tgps_pkg::CMD_LOAD && i_vertex_index != 2'd3) begin
            r_vx[i_vertex_index] <= i_pos_x;
            r_vy[i_vertex_index] <= i_pos_y;
            r_vc[i_vertex_index] <= i_vertex_rgb;
        end
    end

    // Advance pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (adv1) r_s1_valid <= acc && i_command == tgps_pkg::CMD_SHADE;
            if (adv2) r_s2_valid <= r_s1_valid;
        end
    end

    // Capture vertex colours with the products so a later load cannot reach this pixel
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_p       <= n_p;
            r_area    <= n_area;
            r_s1_mode <= i_shade_mode;
            r_s1_c    <= r_vc;
        end
        if (adv2) begin
            r_pix.covered <= cov;
            r_pix.gouraud <= r_s1_mode;
            r_pix.e0      <= e[0];
            r_pix.e1      <= e[1];
            r_pix.e2      <= e[2];
            r_pix.area    <= r_area;
            r_pix.c0      <= r_s1_c[0];
            r_pix.c1      <= r_s1_c[1];
            r_pix.c2      <= r_s1_c[2];
        end
    end

    assign o_valid = r_s2_valid;
    assign o_pix   = r_pix;
endmodule

// File: rtl/core/tgps_queue.sv
// Short queue between front and back ends.
// Depends on tgps_pkg for the pixel transaction type.
module tgps_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tgps_pkg::t_pix i_pix,
    output logic           o_valid,
    input  logic           i_ready,
    output tgps_pkg::t_pix o_pix
);
    tgps_pkg::t_pix r_mem [tgps_pkg::QDepth];
    logic [tgps_pkg::QIdxBits-1:0] r_wp, r_rp;
    logic [tgps_pkg::QIdxBits:0]   r_cnt;
    logic wr, rd;

    assign o_ready = r_cnt != (tgps_pkg::QIdxBits + 1)'(tgps_pkg::QDepth);
    assign o_valid = r_cnt != '0;
    assign wr      = i_valid && o_ready;
    assign rd      = o_valid && i_ready;
    assign o_pix   = r_mem[r_rp];

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (tgps_pkg::QIdxBits + 1)'(wr) - (tgps_pkg::QIdxBits + 1)'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_pix;
    end
endmodule

// File: rtl/core/tgps_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on tgps_pkg for widths; quotient fits in 8 bits.
module tgps_div (
    input  logic                          i_clk,
    input  logic                          i_adv,
    input  logic [tgps_pkg::NumBits-1:0]  i_num,
    input  logic [tgps_pkg::EdgeBits-1:0] i_den,
    output logic [7:0]                    o_quo
);
    localparam int NB = tgps_pkg::NumBits;
    localparam int DB = tgps_pkg::EdgeBits;

    logic [NB-1:0]   r_rem [7];
    logic [DB-1:0]   r_den [7];
    logic [7:0]      r_q   [8];
    logic [NB-1:0]   rem_in [8];
    logic [DB-1:0]   den_in [8];
    logic [7:0]      q_in   [8];
    logic [NB+7:0]   sh     [8];
    logic            ge     [8];

    // Stage inputs and trial subtraction, MSB first
    always_comb begin
        rem_in[0] = i_num;
        den_in[0] = i_den;
        q_in[0]   = '0;
        for (int s = 1; s < 8; s++) begin
            rem_in[s] = r_rem[s-1];
            den_in[s] = r_den[s-1];
            q_in[s]   = r_q[s-1];
        end
        for (int s = 0; s < 8; s++) begin
            sh[s] = (NB + 8)'(den_in[s]) << (7 - s);
            ge[s] = (NB + 8)'(rem_in[s]) >= sh[s];
        end
    end

    // One quotient bit per stage
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int s = 0; s < 7; s++) begin
                r_rem[s] <= ge[s] ? NB'((NB + 8)'(rem_in[s]) - sh[s]) : rem_in[s];
                r_den[s] <= den_in[s];
            end
            for (int s = 0; s < 8; s++) begin
                r_q[s] <= {q_in[s][6:0], ge[s]};
            end
        end
    end

    assign o_quo = r_q[7];
endmodule

// File: rtl/core/tgps_back.sv
// Back end: weighted colour sums and division by the area; flat colour or black selected at the output.
// Depends on tgps_pkg and tgps_div.
module tgps_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tgps_pkg::t_pix i_pix,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_covered,
    output logic [7:0]     o_red,
    output logic [7:0]     o_green,
    output logic [7:0]     o_blue
);
    localparam int NB = tgps_pkg::NumBits;
    localparam int EB = tgps_pkg::EdgeBits;
    localparam int Lat = 11;

    logic adv;
    logic [Lat-1:0] r_v;
    logic signed [NB-1:0] r_m [3][3];
    logic signed [NB-1:0] n_m [3][3];
    logic signed [NB-1:0] r_num [3];
    logic [NB-1:0] r_unum [3];
    logic [EB-1:0] r_den, r_den2;
    logic signed [EB-1:0] r_area, r_area2;
    logic [Lat-1:0] r_cov, r_gou;
    logic [23:0] r_fc [Lat];
    logic [7:0]  q [3];

    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;
    assign o_valid = r_v[Lat-1];

    // Per channel, per vertex products
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_m[c][0] = NB'(i_pix.e0) * $signed({1'b0, i_pix.c0[8*c +: 8]});
            n_m[c][1] = NB'(i_pix.e1) * $signed({1'b0, i_pix.c1[8*c +: 8]});
            n_m[c][2] = NB'(i_pix.e2) * $signed({1'b0, i_pix.c2[8*c +: 8]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[Lat-2:0], i_valid};
        end
    end

    // Sum, fold sign, then divide
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m    <= n_m;
            r_area <= i_pix.area;
            for (int c = 0; c < 3; c++) begin
                r_num[c] <= r_m[c][0] + r_m[c][1] + r_m[c][2];
            end
            r_den   <= r_area[EB-1] ? EB'(-r_area) : EB'(r_area);
            r_area2 <= r_area;
            for (int c = 0; c < 3; c++) begin
                r_unum[c] <= r_area2[EB-1] ? NB'(-r_num[c]) : NB'(r_num[c]);
            end
            r_den2 <= r_den;
            r_cov  <= {r_cov[Lat-2:0], i_pix.covered};
            r_gou  <= {r_gou[Lat-2:0], i_pix.gouraud};
            r_fc[0] <= i_pix.c0;
            for (int s = 1; s < Lat; s++) r_fc[s] <= r_fc[s-1];
        end
    end

    // r_area2 travels with r_num; r_den2 travels with r_unum into the divider
    for (genvar c = 0; c < 3; c++) begin : g_div
        logic [NB-1:0] num_c;
        assign num_c = r_unum[c][NB-1] ? '0 : r_unum[c];
        tgps_div u_div (
            .i_clk (i_clk),
            .i_adv (adv),
            .i_num (num_c),
            .i_den (r_den2),
            .o_quo (q[c])
        );
    end

    assign o_covered = r_cov[Lat-1];
    assign o_red   = !o_covered ? 8'd0 : r_gou[Lat-1] ? q[2] : r_fc[Lat-1][23:16];
    assign o_green = !o_covered ? 8'd0 : r_gou[Lat-1] ? q[1] : r_fc[Lat-1][15:8];
    assign o_blue  = !o_covered ? 8'd0 : r_gou[Lat-1] ? q[0] : r_fc[Lat-1][7:0];
endmodule

// File: rtl/core/tgps_checker.sv
// Port-level checker for the shader, attached by bind.
// Depends on tgps_if through the top level's interface ports.
module tgps_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic covered,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue
);
    a_uncov_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !covered |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
        else $error("uncovered pixel with colour");
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result after reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(covered) && $stable(red))
        else $error("stalled result changed");
endmodule

bind triangle_gouraud_pixel_shader tgps_checker u_tgps_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .covered   (o_out.covered),
    .red       (o_out.red),
    .green     (o_out.green),
    .blue      (o_out.blue)
);

// File: bench/tb_triangle_gouraud_pixel_shader.sv
// Testbench for the Gouraud triangle pixel shader: drives vertex loads and
// pixel transactions, predicts coverage and colour, checks every result.
// Depends on tgps_pkg, tgps_if and the shader RTL.
module tb_triangle_gouraud_pixel_shader;

    typedef struct packed {
        logic        command;
        logic [1:0]  vertex_index;
        logic [10:0] pos_x;
        logic [10:0] pos_y;
        logic [23:0] vertex_rgb;
    } t_item;

    typedef struct packed {
        logic       covered;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_shade;

    localparam int CycleLimit = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic mode_we = 1'b0;
    logic mode_wd = 1'b0;

    tgps_in_if  in_ch ();
    tgps_out_if out_ch ();

    triangle_gouraud_pixel_shader i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_shade_mode_we (mode_we),
        .i_shade_mode_wd (mode_wd),
        .i_in            (in_ch.sink),
        .o_out           (out_ch.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state
    longint tri_x[3];
    longint tri_y[3];
    logic [23:0] tri_rgb[3];
    logic gouraud_on;

    t_item  pending_items[$];
    t_shade expected_pixels[$];
    int     mismatches = 0;
    longint cycles = 0;
    int     sink_hold = 0;

    function automatic longint edge_val(longint ax, longint ay, longint bx,
                                        longint by, longint px, longint py);
        return (ay - by) * px + (bx - ax) * py + ax * by - bx * ay;
    endfunction

    function automatic logic [7:0] mix_channel(int sh, longint e0, longint e1,
                                               longint e2, longint area);
        longint num;
        num = e0 * longint'((tri_rgb[0] >> sh) & 8'hFF)
            + e1 * longint'((tri_rgb[1] >> sh) & 8'hFF)
            + e2 * longint'((tri_rgb[2] >> sh) & 8'hFF);
        if (area < 0) begin
            num = -num;
            area = -area;
        end
        if (num < 0) num = 0;
        return 8'((num / area) & 255);
    endfunction

    // Advance the predictor by one accepted transaction
    task automatic shade_predict(t_item it);
        longint px, py, e0, e1, e2, area;
        t_shade r;
        px = longint'($signed(it.pos_x));
        py = longint'($signed(it.pos_y));
        if (it.command == tgps_pkg::CMD_LOAD) begin
            if (it.vertex_index < 3) begin
                tri_x[it.vertex_index] = px;
                tri_y[it.vertex_index] = py;
                tri_rgb[it.vertex_index] = it.vertex_rgb;
            end
            return;
        end
        e0 = edge_val(tri_x[1], tri_y[1], tri_x[2], tri_y[2], px, py);
        e1 = edge_val(tri_x[2], tri_y[2], tri_x[0], tri_y[0], px, py);
        e2 = edge_val(tri_x[0], tri_y[0], tri_x[1], tri_y[1], px, py);
        area = edge_val(tri_x[0], tri_y[0], tri_x[1], tri_y[1], tri_x[2], tri_y[2]);
        r = '0;
        r.covered = area != 0 && (e0 == 0 || (e0 > 0) == (area > 0))
                    && (e1 == 0 || (e1 > 0) == (area > 0))
                    && (e2 == 0 || (e2 > 0) == (area > 0));
        if (r.covered) begin
            if (gouraud_on) begin
                r.red   = mix_channel(16, e0, e1, e2, area);
                r.green = mix_channel(8, e0, e1, e2, area);
                r.blue  = mix_channel(0, e0, e1, e2, area);
            end else begin
                r.red = tri_rgb[0][23:16];
                r.green = tri_rgb[0][15:8];
                r.blue = tri_rgb[0][7:0];
            end
        end
        expected_pixels.push_back(r);
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Driver: present queued transactions with random gaps
    int src_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_ch.ready) begin
            // hold until accepted
        end else begin
            if (in_ch.valid) shade_predict(t_item'({in_ch.command, in_ch.vertex_index,
                in_ch.pos_x, in_ch.pos_y, in_ch.vertex_rgb}));
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                t_item it;
                it = pending_items.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.command <= it.command;
                in_ch.vertex_index <= it.vertex_index;
                in_ch.pos_x <= it.pos_x;
                in_ch.pos_y <= it.pos_y;
                in_ch.vertex_rgb <= it.vertex_rgb;
                src_gap <= gap_len();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Count down the long receiver hold
    always @(posedge i_clk) begin
        if (sink_hold > 0) sink_hold <= sink_hold - 1;
    end

    // Monitor: random stalls, compare each transaction with the oldest expectation
    int sink_gap = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_pixels.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected pixel: cov %0d rgb %h%h%h", out_ch.covered,
                                 out_ch.red, out_ch.green, out_ch.blue);
                    mismatches <= mismatches + 1;
                end else begin
                    t_shade exp_px;
                    exp_px = expected_pixels.pop_front();
                    if (exp_px != t_shade'({out_ch.covered, out_ch.red, out_ch.green,
                                            out_ch.blue})) begin
                        if (mismatches < 10)
                            $display("pixel mismatch: exp cov %0d rgb %h  got cov %0d rgb %h%h%h",
                                     exp_px.covered, exp_px[23:0], out_ch.covered,
                                     out_ch.red, out_ch.green, out_ch.blue);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (sink_hold > 0) begin
                out_ch.ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                sink_gap <= gap_len();
            end
        end
    end

    // Timeout watchdog
    always @(posedge i_clk) begin
        if (cycles > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_item load_item(int idx, int x, int y, logic [23:0] rgb);
        t_item it;
        it.command = tgps_pkg::CMD_LOAD;
        it.vertex_index = 2'(idx);
        it.pos_x = 11'(x);
        it.pos_y = 11'(y);
        it.vertex_rgb = rgb;
        return it;
    endfunction

    function automatic t_item pixel_item(int x, int y);
        t_item it;
        it = load_item($urandom_range(0, 3), x, y, 24'($urandom));
        it.command = tgps_pkg::CMD_SHADE;
        return it;
    endfunction

    // Block until every queued transaction is in and every result is out
    task automatic drain();
        while (pending_items.size() > 0 || in_ch.valid || expected_pixels.size() > 0)
            @(negedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_mode(logic m);
        @(posedge i_clk);
        mode_we <= 1'b1;
        mode_wd <= m;
        gouraud_on = m;
        @(posedge i_clk);
        mode_we <= 1'b0;
    endtask

    // Random triangle followed by pixels mostly inside its bounding box, mixed with ignored index-3 loads
    task automatic random_triangle(int span, int npix);
        int x0, y0, w, lx, hx, ly, hy;
        x0 = $urandom_range(0, 2047) - 1024;
        y0 = $urandom_range(0, 2047) - 1024;
        lx = 1023; hx = -1024; ly = 1023; hy = -1024;
        for (int k = 0; k < 3; k++) begin
            int vx, vy;
            vx = x0 + $urandom_range(0, span) - span / 2;
            vy = y0 + $urandom_range(0, span) - span / 2;
            if (vx < -1024) vx = -1024;
            if (vx > 1023) vx = 1023;
            if (vy < -1024) vy = -1024;
            if (vy > 1023) vy = 1023;
            lx = vx < lx ? vx : lx; hx = vx > hx ? vx : hx;
            ly = vy < ly ? vy : ly; hy = vy > hy ? vy : hy;
            pending_items.push_back(load_item(k, vx, vy, 24'($urandom)));
        end
        for (int k = 0; k < npix; k++) begin
            w = $urandom_range(0, 9);
            if (w == 0)
                pending_items.push_back(pixel_item($urandom_range(0, 2047) - 1024,
                                                   $urandom_range(0, 2047) - 1024));
            else if (w == 1)
                pending_items.push_back(load_item(3, $urandom_range(0, 2047),
                                                  $urandom_range(0, 2047), 24'($urandom)));
            else
                pending_items.push_back(pixel_item(lx + int'($urandom_range(0, hx - lx)),
                                                   ly + int'($urandom_range(0, hy - ly))));
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.command = tgps_pkg::CMD_LOAD;
        in_ch.vertex_index = '0;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.vertex_rgb = '0;
        out_ch.ready = 1'b0;
        for (int k = 0; k < 3; k++) begin
            tri_x[k] = 0; tri_y[k] = 0; tri_rgb[k] = '0;
        end
        gouraud_on = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: degenerate reset triangle, extremes, ignored load, flat mode
        pending_items.push_back(pixel_item(0, 0));
        pending_items.push_back(load_item(0, -1024, -1024, 24'hFFFFFF));
        pending_items.push_back(load_item(1, 1023, -1024, 24'h000000));
        pending_items.push_back(load_item(2, -1024, 1023, 24'hFF00FF));
        pending_items.push_back(load_item(3, 5, 5, 24'h123456));
        pending_items.push_back(pixel_item(-1024, -1024));
        pending_items.push_back(pixel_item(1023, -1024));
        pending_items.push_back(pixel_item(-1024, 1023));
        pending_items.push_back(pixel_item(0, 0));
        pending_items.push_back(pixel_item(-1, -1));
        pending_items.push_back(pixel_item(1023, 1023));
        pending_items.push_back(load_item(1, -1024, 1023, 24'h00FF00));
        pending_items.push_back(load_item(2, 1023, -1024, 24'h0000FF));
        pending_items.push_back(pixel_item(-100, -100));
        pending_items.push_back(pixel_item(1023, 1023));
        pending_items.push_back(load_item(2, 0, 0, 24'h0000FF));
        pending_items.push_back(pixel_item(-1024, 0));
        drain();
        write_mode(1'b0);
        pending_items.push_back(pixel_item(-1000, -1000));
        pending_items.push_back(pixel_item(500, 500));
        drain();
        write_mode(1'b1);

        // Long receiver stall while the sender keeps offering
        sink_hold = 200;
        random_triangle(60, 40);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_mode(ph[0]);
            for (int t = 0; t < 12; t++)
                random_triangle(t == 0 ? 2047 : $urandom_range(2, 80), 8);
            drain();
        end
        write_mode(1'b1);
        drain();

        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
